// ----- src/mexp_pkg.sv -----
// Shared widths, register codes and control structs for the modular exponentiation block.
`default_nettype none

package mexp_pkg;

  // Operand widths.
  localparam int MOD_WIDTH       = 32;
  localparam int EXP_WIDTH       = 64;
  localparam int BASE_WIDTH      = 64;
  localparam int OUT_WIDTH       = 32;
  localparam int CFG_DATA_WIDTH  = 64;
  localparam int CFG_INDEX_WIDTH = 2;

  // The serial multiply step counter must hold the longest operand length.
  localparam int CNT_WIDTH = $clog2(BASE_WIDTH + 1);
  localparam logic [CNT_WIDTH-1:0] STEPS_REDUCE = CNT_WIDTH'(BASE_WIDTH);
  localparam logic [CNT_WIDTH-1:0] STEPS_MULT   = CNT_WIDTH'(MOD_WIDTH);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT = CFG_INDEX_WIDTH'(1);

  // Register reset values.
  localparam logic [MOD_WIDTH-1:0] MODULUS_RESET  = MOD_WIDTH'(3233);
  localparam logic [EXP_WIDTH-1:0] EXPONENT_RESET = EXP_WIDTH'(17);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // start a new transaction: copy exponent, set accumulator to one
    logic start_red;  // reduce the incoming base by the modulus
    logic start_mul;  // accumulator times power
    logic start_sqr;  // power times power
    logic cap_acc;    // take the unit result into the accumulator
    logic cap_pw;     // take the unit result into the power
    logic shift_exp;  // move on to the next exponent bit
    logic publish;    // load the output register
  } mexp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic unit_done;
    logic exp_zero;
    logic exp_lsb;
    logic out_full;
  } mexp_sts_t;

endpackage

`default_nettype wire

// ----- src/mexp_if.sv -----
// Valid/ready channel interfaces for the base input and the result output.
`default_nettype none

interface mexp_base_if import mexp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [BASE_WIDTH-1:0] base_value;

  modport source (output valid, output base_value, input ready);
  modport sink   (input valid, input base_value, output ready);
endinterface

interface mexp_result_if import mexp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_WIDTH-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

`default_nettype wire

// ----- src/mexp_mulmod.sv -----
// Bit-serial interleaved modular multiplier, one operand bit per cycle, MSB first.
`default_nettype none

module mexp_mulmod import mexp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [MOD_WIDTH-1:0]  op_a,
  input  logic [BASE_WIDTH-1:0] op_bits,
  input  logic [CNT_WIDTH-1:0]  steps,
  input  logic [MOD_WIDTH-1:0]  modulus,
  output logic                  done,
  output logic [MOD_WIDTH-1:0]  result
);

  logic                  busy;
  logic [CNT_WIDTH-1:0]  cnt;
  logic [BASE_WIDTH-1:0] bits;
  logic [MOD_WIDTH-1:0]  a_reg;
  logic [MOD_WIDTH-1:0]  r;
  logic [MOD_WIDTH-1:0]  r_next;

  logic [MOD_WIDTH+1:0] t;
  logic [MOD_WIDTH+1:0] m1;
  logic [MOD_WIDTH+1:0] m2;

  // With r below m and a at most m, 2r + a stays below 3m, so at most 2m comes off.
  always_comb begin
    m1 = {2'b00, modulus};
    m2 = {1'b0, modulus, 1'b0};
    t  = {1'b0, r, 1'b0} + (bits[BASE_WIDTH-1] ? {2'b00, a_reg} : '0);
    if (t >= m2) begin
      r_next = MOD_WIDTH'(t - m2);
    end else if (t >= m1) begin
      r_next = MOD_WIDTH'(t - m1);
    end else begin
      r_next = MOD_WIDTH'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_WIDTH'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_WIDTH'(1))) begin
        busy <= 1'b0;
      end
    end
    if (start) begin
      r     <= '0;
      cnt   <= steps;
      bits  <= op_bits;
      a_reg <= op_a;
    end else if (busy) begin
      r    <= r_next;
      cnt  <= cnt - CNT_WIDTH'(1);
      bits <= {bits[BASE_WIDTH-2:0], 1'b0};
    end
  end

  assign result = r;

  a_fully_reduced: assert property (@(posedge clk) disable iff (rst)
    done && (modulus != '0) |-> (r < modulus))
    else $error("multiplier result not below the modulus");

endmodule

`default_nettype wire

// ----- src/mexp_datapath.sv -----
// Configuration registers, exponentiation operands, shared multiplier and output register.
`default_nettype none

module mexp_datapath import mexp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_enable,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic [BASE_WIDTH-1:0]      base_value,
  input  mexp_cmd_t                  cmd,
  output mexp_sts_t                  sts,
  mexp_result_if.source              result_out
);

  logic [MOD_WIDTH-1:0] modulus;
  logic [EXP_WIDTH-1:0] exponent;
  logic [EXP_WIDTH-1:0] exp_work;
  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] pw;
  logic                 out_valid;
  logic [OUT_WIDTH-1:0] out_data;

  logic                  unit_start;
  logic [MOD_WIDTH-1:0]  unit_a;
  logic [BASE_WIDTH-1:0] unit_bits;
  logic [CNT_WIDTH-1:0]  unit_steps;
  logic                  unit_done;
  logic [MOD_WIDTH-1:0]  unit_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= MODULUS_RESET;
      exponent <= EXPONENT_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_MODULUS:  modulus  <= cfg_data[MOD_WIDTH-1:0];
        REG_EXPONENT: exponent <= cfg_data[EXP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier; reduction multiplies the base by one.
  always_comb begin
    unit_start = cmd.start_red || cmd.start_mul || cmd.start_sqr;
    if (cmd.start_red) begin
      unit_a     = MOD_WIDTH'(1);
      unit_bits  = base_value;
      unit_steps = STEPS_REDUCE;
    end else if (cmd.start_mul) begin
      unit_a     = acc;
      unit_bits  = {pw, {(BASE_WIDTH-MOD_WIDTH){1'b0}}};
      unit_steps = STEPS_MULT;
    end else begin
      unit_a     = pw;
      unit_bits  = {pw, {(BASE_WIDTH-MOD_WIDTH){1'b0}}};
      unit_steps = STEPS_MULT;
    end
  end

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (unit_start),
    .op_a    (unit_a),
    .op_bits (unit_bits),
    .steps   (unit_steps),
    .modulus (modulus),
    .done    (unit_done),
    .result  (unit_result)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      exp_work <= exponent;
      acc      <= MOD_WIDTH'(1);
    end else begin
      if (cmd.shift_exp) begin
        exp_work <= {1'b0, exp_work[EXP_WIDTH-1:1]};
      end
      if (cmd.cap_acc) begin
        acc <= unit_result;
      end
    end
    if (cmd.cap_pw) begin
      pw <= unit_result;
    end
  end

  // A zero modulus admits no reduction and always gives zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.publish) begin
      out_data <= (modulus == '0) ? '0 : OUT_WIDTH'(acc);
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.power_result = out_data;

  assign sts.unit_done = unit_done;
  assign sts.exp_zero  = (exp_work == '0);
  assign sts.exp_lsb   = exp_work[0];
  assign sts.out_full  = out_valid && !result_out.ready;

endmodule

`default_nettype wire

// ----- src/mexp_controller.sv -----
// Sequencer for reduction and the square-and-multiply rounds.
`default_nettype none

module mexp_controller import mexp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  mexp_sts_t sts,
  output mexp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_WAIT,
    S_CHECK,
    S_MUL_WAIT,
    S_SQR_WAIT,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load      = 1'b1;
          cmd.start_red = 1'b1;
          state_next    = S_RED_WAIT;
        end
      end
      S_RED_WAIT: begin
        if (sts.unit_done) begin
          cmd.cap_pw = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.exp_zero) begin
          state_next = S_OUT;
        end else if (sts.exp_lsb) begin
          cmd.start_mul = 1'b1;
          state_next    = S_MUL_WAIT;
        end else begin
          cmd.start_sqr = 1'b1;
          state_next    = S_SQR_WAIT;
        end
      end
      S_MUL_WAIT: begin
        // The square reads the power, which the multiply leaves unchanged.
        if (sts.unit_done) begin
          cmd.cap_acc   = 1'b1;
          cmd.start_sqr = 1'b1;
          state_next    = S_SQR_WAIT;
        end
      end
      S_SQR_WAIT: begin
        if (sts.unit_done) begin
          cmd.cap_pw    = 1'b1;
          cmd.shift_exp = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_OUT: begin
        if (!sts.out_full) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/modular_exponentiation.sv -----
// Top level of the modular exponentiation block: base in, base^exponent mod modulus out.
//
// Each transaction on base_in carries a 64-bit base; exactly one transaction on
// result_out follows, carrying base^exponent mod modulus. An exponent of zero gives 1,
// and a zero modulus gives 0. The modulus and exponent are written through the plain
// configuration port (index 0 modulus, index 1 exponent) while the block is idle.
//
// The block works on one base at a time. A single bit-serial modular multiplier does
// all the arithmetic, one operand bit per cycle: the base reduction walks all 64 bits
// of the base, and every square or multiply the MOD_WIDTH bits of the power.
// The next base is taken as soon as the previous result sits in the output register.
//
// Synchronous reset returns the sequencer to idle, empties the output register and
// restores the modulus to 3233 and the exponent to 17. If the receiver stalls, the
// result waits in the output register; a further base may then be processed, but its
// result is held back until the output register has been emptied.
`default_nettype none

module modular_exponentiation import mexp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_enable,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  mexp_base_if.sink                  base_in,
  mexp_result_if.source              result_out
);

  mexp_cmd_t cmd;
  mexp_sts_t sts;
  logic      in_ready;

  // The sequencer decides when a base is taken and which operation runs next.
  mexp_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (base_in.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign base_in.ready = in_ready;

  // The datapath holds the registers, operands, multiplier and output stage.
  mexp_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .base_value       (base_in.base_value),
    .cmd              (cmd),
    .sts              (sts),
    .result_out       (result_out)
  );

  // Only one base is in flight: after an accepted transaction the input closes.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    base_in.valid && base_in.ready |=> !base_in.ready)
    else $error("input accepted while a base was still in progress");

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !sts.out_full)
    else $error("output register overwritten before the transaction completed");

  // The shared multiplier is started for at most one operation at a time.
  a_single_start: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start_red, cmd.start_mul, cmd.start_sqr}))
    else $error("multiplier started for two operations at once");

endmodule

`default_nettype wire
